// ===== src/sync_length_xor_frame_receiver_top_macros.svh =====
// assertion macros for the sync / length / xor frame receiver
// no dependencies; included by the modules that carry assertions
`ifndef SYNC_LENGTH_XOR_FRAME_RECEIVER_TOP_MACROS_SVH
`define SYNC_LENGTH_XOR_FRAME_RECEIVER_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define SLJF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sljf assertion failed");

// next-cycle implication, disabled while reset is high
`define SLJF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sljf assertion failed");

`endif

// ===== src/sljf_pkg.sv =====
// types and constants for the sync / length / xor frame receiver
// no dependencies; used by sljf_parser and the top level
`default_nettype none

package sljf_pkg;

   localparam logic [7:0] SYNC_FIRST  = 8'hAA;
   localparam logic [7:0] SYNC_SECOND = 8'h55;

   // payload bytes below this index are passed out, later ones only counted
   localparam int BUF_DEPTH = 256;

   typedef enum logic [2:0] {
      PHASE_HUNT     = 3'd0,
      PHASE_SYNC2    = 3'd1,
      PHASE_TYPE     = 3'd2,
      PHASE_LEN_LO   = 3'd3,
      PHASE_LEN_HI   = 3'd4,
      PHASE_PAYLOAD  = 3'd5,
      PHASE_CHECKSUM = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_ACCEPT  = 2'd1,
      KIND_REJECT  = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  frame_type;
      logic [7:0]  data_byte;
      logic [7:0]  byte_index;
      logic [15:0] frame_length;
   } beat_type;

   typedef struct packed {
      logic     valid;
      beat_type beat;
   } result_type;

endpackage

`default_nettype wire

// ===== src/sync_length_xor_frame_receiver_top.sv =====
// Receives one byte per req beat and deframes the stream: it hunts for the sync pair
// 0xAA 0x55, takes a type byte and a little-endian 16-bit length, then passes each
// payload byte out with its index (only the first 256; later ones are counted) and
// finally reports the frame as accepted or rejected by its xor checksum byte together
// with the type and the counted length. A byte is taken every cycle in which req_ready is
// high; its result, if any, appears on rsp in the cycle after acceptance, from the single
// output register. req_ready is high whenever that register is empty or being read in the
// same cycle, so a stalled rsp side stalls req after one held beat.
// depends on sljf_pkg, sljf_parser and the assertion macro header
`default_nettype none

`include "sync_length_xor_frame_receiver_top_macros.svh"

module sync_length_xor_frame_receiver_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [7:0]  req_rx_byte,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [1:0]  rsp_kind,
   output      logic [7:0]  rsp_frame_type,
   output      logic [7:0]  rsp_data_byte,
   output      logic [7:0]  rsp_byte_index,
   output      logic [15:0] rsp_frame_length
);

   logic                 req_accept;
   sljf_pkg::result_type result;

   logic               rsp_valid_ff, rsp_valid_in;
   sljf_pkg::beat_type rsp_beat_ff, rsp_beat_in;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   sljf_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (req_accept),
      .rx_byte (req_rx_byte),
      .result  (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_beat_in  = rsp_beat_ff;
      if (rsp_ready)
         rsp_valid_in = 1'b0;
      if (req_accept) begin
         rsp_valid_in = result.valid;
         rsp_beat_in  = result.beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload register needs no reset
   always_ff @(posedge clock) begin
      rsp_beat_ff <= rsp_beat_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_beat_ff.kind;
   assign rsp_frame_type   = rsp_beat_ff.frame_type;
   assign rsp_data_byte    = rsp_beat_ff.data_byte;
   assign rsp_byte_index   = rsp_beat_ff.byte_index;
   assign rsp_frame_length = rsp_beat_ff.frame_length;

   `SLJF_ASSERT_NOW(a_ready_when_empty, clock, reset, !rsp_valid, req_ready)
   `SLJF_ASSERT_NOW(a_stall_blocks_req, clock, reset, rsp_valid && !rsp_ready, !req_ready)
   `SLJF_ASSERT_NOW(a_payload_no_length, clock, reset,
      rsp_valid && rsp_kind == sljf_pkg::KIND_PAYLOAD, rsp_frame_length == 16'd0)
   `SLJF_ASSERT_NOW(a_status_no_data, clock, reset,
      rsp_valid && rsp_kind != sljf_pkg::KIND_PAYLOAD,
      rsp_data_byte == 8'd0 && rsp_byte_index == 8'd0)
   `SLJF_ASSERT_NEXT(a_idle_no_rsp, clock, reset,
      !req_accept && (rsp_ready || !rsp_valid), !rsp_valid)

endmodule

`default_nettype wire

// ===== src/sljf_parser.sv =====
// frame parser: sync hunt, header latch, payload count and xor checksum
// depends on sljf_pkg; one byte is consumed per cycle in which step is high
`default_nettype none

module sljf_parser (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire logic [7:0]          rx_byte,
   output sljf_pkg::result_type     result
);

   sljf_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  held_type_ff, held_type_in;
   logic [15:0] exp_len_ff, exp_len_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  check_ff, check_in;

   logic [15:0] count_inc;
   logic [15:0] full_len;
   logic        in_buffer;

   assign count_inc = count_ff + 16'd1;
   assign full_len  = {rx_byte, exp_len_ff[7:0]};
   assign in_buffer = {1'b0, count_ff} < 17'(sljf_pkg::BUF_DEPTH);

   // next state
   always_comb begin
      phase_in     = phase_ff;
      held_type_in = held_type_ff;
      exp_len_in   = exp_len_ff;
      count_in     = count_ff;
      check_in     = check_ff;
      if (step) begin
         case (phase_ff)
            sljf_pkg::PHASE_HUNT: begin
               if (rx_byte == sljf_pkg::SYNC_FIRST)
                  phase_in = sljf_pkg::PHASE_SYNC2;
            end
            sljf_pkg::PHASE_SYNC2: begin
               phase_in = (rx_byte == sljf_pkg::SYNC_SECOND) ? sljf_pkg::PHASE_TYPE
                                                              : sljf_pkg::PHASE_HUNT;
            end
            sljf_pkg::PHASE_TYPE: begin
               held_type_in = rx_byte;
               check_in     = rx_byte;
               phase_in     = sljf_pkg::PHASE_LEN_LO;
            end
            sljf_pkg::PHASE_LEN_LO: begin
               exp_len_in = {8'd0, rx_byte};
               check_in   = check_ff ^ rx_byte;
               phase_in   = sljf_pkg::PHASE_LEN_HI;
            end
            sljf_pkg::PHASE_LEN_HI: begin
               exp_len_in = full_len;
               check_in   = check_ff ^ rx_byte;
               count_in   = 16'd0;
               // zero length skips straight to the checksum byte
               phase_in   = (full_len == 16'd0) ? sljf_pkg::PHASE_CHECKSUM
                                                : sljf_pkg::PHASE_PAYLOAD;
            end
            sljf_pkg::PHASE_PAYLOAD: begin
               check_in = check_ff ^ rx_byte;
               count_in = count_inc;
               if (count_inc >= exp_len_ff)
                  phase_in = sljf_pkg::PHASE_CHECKSUM;
            end
            sljf_pkg::PHASE_CHECKSUM: begin
               phase_in = sljf_pkg::PHASE_HUNT;
            end
            default: begin
               phase_in = sljf_pkg::PHASE_HUNT;
            end
         endcase
      end
   end

   // result beat for the byte being consumed
   always_comb begin
      result.valid             = 1'b0;
      result.beat.kind         = sljf_pkg::KIND_PAYLOAD;
      result.beat.frame_type   = held_type_ff;
      result.beat.data_byte    = 8'd0;
      result.beat.byte_index   = 8'd0;
      result.beat.frame_length = 16'd0;
      case (phase_ff)
         sljf_pkg::PHASE_PAYLOAD: begin
            result.valid           = in_buffer;
            result.beat.data_byte  = rx_byte;
            result.beat.byte_index = count_ff[7:0];
         end
         sljf_pkg::PHASE_CHECKSUM: begin
            result.valid             = 1'b1;
            result.beat.kind         = (rx_byte == check_ff) ? sljf_pkg::KIND_ACCEPT
                                                             : sljf_pkg::KIND_REJECT;
            result.beat.frame_length = count_ff;
         end
         default: begin
            result.valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= sljf_pkg::PHASE_HUNT;
         held_type_ff <= 8'd0;
         exp_len_ff   <= 16'd0;
         count_ff     <= 16'd0;
         check_ff     <= 8'd0;
      end else begin
         phase_ff     <= phase_in;
         held_type_ff <= held_type_in;
         exp_len_ff   <= exp_len_in;
         count_ff     <= count_in;
         check_ff     <= check_in;
      end
   end

endmodule

`default_nettype wire

// ===== tb/sv/sljf_frame_checker.sv =====
// frame checker for the sync / length / xor frame receiver: watches req and rsp,
// predicts the rsp beats from the accepted bytes and compares them field by field
// depends on sljf_pkg for the beat struct, kind and phase enums and the sync constants
module sljf_frame_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [1:0]  rsp_kind,
   input  wire logic [7:0]  rsp_frame_type,
   input  wire logic [7:0]  rsp_data_byte,
   input  wire logic [7:0]  rsp_byte_index,
   input  wire logic [15:0] rsp_frame_length,
   output int unsigned      fault_count,
   output int unsigned      pending_beats
);

   sljf_pkg::phase_type phase;
   logic [7:0]          held_type;
   logic [7:0]          run_xor;
   logic [15:0]         want_len;
   logic [15:0]         seen_len;

   sljf_pkg::beat_type  expected_beats[$];
   int unsigned         faults = 0;

   assign fault_count   = faults;
   assign pending_beats = expected_beats.size();

   function automatic sljf_pkg::beat_type shape_beat(input sljf_pkg::kind_type k,
                                                     input logic [7:0] ft,
                                                     input logic [7:0] d,
                                                     input logic [7:0] idx,
                                                     input logic [15:0] n);
      sljf_pkg::beat_type bt;
      bt.kind         = k;
      bt.frame_type   = ft;
      bt.data_byte    = d;
      bt.byte_index   = idx;
      bt.frame_length = n;
      return bt;
   endfunction

   // advance the deframer by one accepted byte, queue the beat it produces if any
   task automatic deframe_byte(input logic [7:0] b);
      case (phase)
         sljf_pkg::PHASE_HUNT: begin
            if (b == sljf_pkg::SYNC_FIRST) phase = sljf_pkg::PHASE_SYNC2;
         end
         sljf_pkg::PHASE_SYNC2: begin
            phase = (b == sljf_pkg::SYNC_SECOND) ? sljf_pkg::PHASE_TYPE : sljf_pkg::PHASE_HUNT;
         end
         sljf_pkg::PHASE_TYPE: begin
            held_type = b;
            run_xor   = b;
            phase     = sljf_pkg::PHASE_LEN_LO;
         end
         sljf_pkg::PHASE_LEN_LO: begin
            want_len = {8'h00, b};
            run_xor  = run_xor ^ b;
            phase    = sljf_pkg::PHASE_LEN_HI;
         end
         sljf_pkg::PHASE_LEN_HI: begin
            want_len[15:8] = b;
            run_xor        = run_xor ^ b;
            seen_len       = 16'h0000;
            // zero length skips straight to the checksum byte
            phase = (want_len == 16'h0000) ? sljf_pkg::PHASE_CHECKSUM : sljf_pkg::PHASE_PAYLOAD;
         end
         sljf_pkg::PHASE_PAYLOAD: begin
            // bytes past the buffer depth are only counted and folded into the xor
            if (seen_len < sljf_pkg::BUF_DEPTH)
               expected_beats.push_back(shape_beat(sljf_pkg::KIND_PAYLOAD, held_type, b,
                                                   seen_len[7:0], 16'h0000));
            run_xor  = run_xor ^ b;
            seen_len = seen_len + 16'd1;
            if (seen_len >= want_len) phase = sljf_pkg::PHASE_CHECKSUM;
         end
         sljf_pkg::PHASE_CHECKSUM: begin
            expected_beats.push_back(shape_beat((b == run_xor) ? sljf_pkg::KIND_ACCEPT
                                                               : sljf_pkg::KIND_REJECT,
                                                held_type, 8'h00, 8'h00, seen_len));
            phase = sljf_pkg::PHASE_HUNT;
         end
         default: begin
            phase = sljf_pkg::PHASE_HUNT;
         end
      endcase
   endtask

   task automatic check_rsp_beat();
      sljf_pkg::beat_type got;
      sljf_pkg::beat_type want;
      got = shape_beat(sljf_pkg::kind_type'(rsp_kind), rsp_frame_type, rsp_data_byte,
                       rsp_byte_index, rsp_frame_length);
      if (expected_beats.size() == 0) begin
         faults++;
         if (faults <= 10)
            $display("frame checker: unexpected rsp beat kind %0d type %02h data %02h idx %0d len %0d",
                     got.kind, got.frame_type, got.data_byte, got.byte_index, got.frame_length);
      end else begin
         want = expected_beats.pop_front();
         if (got.kind != want.kind || got.frame_type != want.frame_type ||
             got.data_byte != want.data_byte || got.byte_index != want.byte_index ||
             got.frame_length != want.frame_length) begin
            faults++;
            if (faults <= 10) begin
               $display("frame checker: expected kind %0d type %02h data %02h idx %0d len %0d",
                        want.kind, want.frame_type, want.data_byte, want.byte_index,
                        want.frame_length);
               $display("frame checker: actual   kind %0d type %02h data %02h idx %0d len %0d",
                        got.kind, got.frame_type, got.data_byte, got.byte_index,
                        got.frame_length);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         phase     = sljf_pkg::PHASE_HUNT;
         held_type = 8'h00;
         run_xor   = 8'h00;
         want_len  = 16'h0000;
         seen_len  = 16'h0000;
         expected_beats.delete();
      end else begin
         // a beat leaving now was predicted on an earlier edge, so compare first
         if (rsp_valid && rsp_ready) check_rsp_beat();
         if (req_valid && req_ready) deframe_byte(req_rx_byte);
      end
   end

endmodule

// ===== tb/sv/tb_sync_length_xor_frame_receiver_top.sv =====
// testbench top for the sync / length / xor frame receiver: clock, reset, byte stream
// with bursty gaps, rsp stalls and the final verdict
// depends on sljf_pkg, sync_length_xor_frame_receiver_top and sljf_frame_checker
module tb_sync_length_xor_frame_receiver_top;

   localparam int unsigned ITEM_TARGET  = 1800;
   localparam int unsigned CYCLE_LIMIT  = 3_000_000;
   localparam int unsigned DRAIN_CYCLES = 16;

   typedef enum logic [1:0] {
      DRAIN_FREE   = 2'd0,
      DRAIN_COIN   = 2'd1,
      DRAIN_SPARSE = 2'd2,
      DRAIN_STRIDE = 2'd3
   } drain_mode_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_frame_type;
   logic [7:0]  rsp_data_byte;
   logic [7:0]  rsp_byte_index;
   logic [15:0] rsp_frame_length;

   int unsigned fault_count;
   int unsigned pending_beats;

   int unsigned    burst_left  = 0;
   int unsigned    items_sent  = 0;
   int unsigned    cycle_count = 0;
   int unsigned    drain_left  = 0;
   int unsigned    drain_tick  = 0;
   drain_mode_type drain_mode  = DRAIN_FREE;

   sync_length_xor_frame_receiver_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_frame_type   (rsp_frame_type),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_frame_length (rsp_frame_length)
   );

   sljf_frame_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_frame_type   (rsp_frame_type),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_frame_length (rsp_frame_length),
      .fault_count      (fault_count),
      .pending_beats    (pending_beats)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("sync_length_xor_frame_receiver_top: mismatch");
         $finish;
      end
   end

   // receiver back-pressure: switches at random between four stall patterns
   always @(negedge clock) begin
      if (drain_left == 0) begin
         drain_mode = drain_mode_type'($urandom_range(0, 3));
         drain_left = $urandom_range(8, 80);
      end else begin
         drain_left--;
      end
      drain_tick++;
      case (drain_mode)
         DRAIN_FREE:   rsp_ready <= 1'b1;
         DRAIN_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
         DRAIN_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
         default:      rsp_ready <= ((drain_tick % 5) < 2);
      endcase
   end

   // one beat on req; called and returns at a falling edge
   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      burst_left--;
   endtask

   // well-formed frame with random payload; corrupt flips the checksum byte
   task automatic send_frame(input logic [7:0] ftype, input logic [15:0] len, input bit corrupt);
      logic [7:0] sum;
      logic [7:0] pb;
      sum = ftype ^ len[7:0] ^ len[15:8];
      send_byte(sljf_pkg::SYNC_FIRST);
      send_byte(sljf_pkg::SYNC_SECOND);
      send_byte(ftype);
      send_byte(len[7:0]);
      send_byte(len[15:8]);
      for (int unsigned i = 0; i < len; i++) begin
         pb = 8'($urandom);
         sum = sum ^ pb;
         send_byte(pb);
      end
      if (corrupt) sum = sum ^ 8'($urandom_range(1, 255));
      send_byte(sum);
      items_sent += len + 6;
   endtask

   initial begin
      int unsigned pick;
      int unsigned sel;
      logic [15:0] len;
      logic [7:0]  b;

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // hunt noise, then a repeated first sync and a near-miss second sync
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(sljf_pkg::SYNC_FIRST);
      send_byte(sljf_pkg::SYNC_FIRST);
      send_byte(sljf_pkg::SYNC_FIRST);
      send_byte(8'h54);
      // zero length frames, good and bad checksum, then short frames
      send_frame(8'h00, 16'd0, 1'b0);
      send_frame(8'hFF, 16'd0, 1'b1);
      send_frame(8'hFF, 16'd1, 1'b0);
      send_frame(8'h7E, 16'd2, 1'b1);
      // buffer depth boundary
      send_frame(8'($urandom), 16'd256, 1'b0);
      send_frame(8'($urandom), 16'd257, 1'b1);

      while (items_sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            sel = $urandom_range(0, 19);
            if (sel == 0) len = 16'd0;
            else if (sel < 16) len = 16'($urandom_range(1, 12));
            else if (sel < 19) len = 16'($urandom_range(13, 64));
            else len = 16'($urandom_range(250, 300));
            send_frame(8'($urandom), len, $urandom_range(0, 3) == 0);
         end else if (pick < 80) begin
            send_byte(8'($urandom));
            items_sent++;
         end else if (pick < 92) begin
            // broken sync pair
            b = 8'($urandom);
            if (b == sljf_pkg::SYNC_SECOND) b = sljf_pkg::SYNC_FIRST;
            send_byte(sljf_pkg::SYNC_FIRST);
            send_byte(b);
            items_sent += 2;
         end else begin
            // header cut short: following bytes are swallowed as payload
            send_byte(sljf_pkg::SYNC_FIRST);
            send_byte(sljf_pkg::SYNC_SECOND);
            send_byte(8'($urandom));
            send_byte(8'($urandom_range(1, 8)));
            send_byte(8'h00);
            items_sent += 5;
         end
      end

      send_frame(8'($urandom), 16'd3, 1'b0);

      req_valid <= 1'b0;
      while (pending_beats != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fault_count == 0)
         $display("sync_length_xor_frame_receiver_top: match");
      else
         $display("sync_length_xor_frame_receiver_top: mismatch");
      $finish;
   end

endmodule
